@@ design/swm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sliding window median filter.
// No dependencies; used by every module of the block.
package swm_pkg;

    localparam int DATA_W         = 32;
    localparam int WS_W           = 7;
    localparam int MAX_WINDOW_DEF = 64;

    // Result queue: one entry in flight from the capture stage plus two buffered
    localparam int OFIFO_DEPTH = 3;
    localparam int OFIFO_PTR_W = 2;

    // Broadcast to every cell of the sorted chain
    typedef struct packed {
        logic              clr;     // drop the whole window before this sample
        logic              ins;     // insert sample, age the survivors
        logic              evict;   // remove the oldest entry
        logic [DATA_W-1:0] sample;
    } cell_ctrl_t;

endpackage

@@ design/swm_cell.sv @@
`timescale 1ns / 1ps
// One cell of the sorted window chain: holds one sample and its age.
// Depends on swm_pkg; neighbors are wired by sliding_window_median.
module swm_cell #(
    parameter int AGE_W = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swm_pkg::cell_ctrl_t           ctrl,
    input  logic [AGE_W-1:0]              oldest_age,
    input  logic                          left_vld,
    input  logic [AGE_W-1:0]              left_age,
    input  logic [swm_pkg::DATA_W-1:0]    left_val,
    input  logic                          left_le,
    input  logic                          right_vld,
    input  logic [AGE_W-1:0]              right_age,
    input  logic [swm_pkg::DATA_W-1:0]    right_val,
    input  logic                          right_le,
    input  logic                          below_in,
    output logic                          below_out,
    output logic                          vld,
    output logic [AGE_W-1:0]              age,
    output logic [swm_pkg::DATA_W-1:0]    val,
    output logic                          le
);

    logic                       vld_reg, vld_next;
    logic [AGE_W-1:0]           age_reg, age_next;
    logic [swm_pkg::DATA_W-1:0] val_reg, val_next;
    logic                       ev;
    logic                       at_or_past;
    logic                       r_vld;
    logic [AGE_W-1:0]           r_age;
    logic [swm_pkg::DATA_W-1:0] r_val;
    logic                       r_le;
    logic                       l_vld;
    logic [AGE_W-1:0]           l_age;
    logic [swm_pkg::DATA_W-1:0] l_val;
    logic                       l_le;

    assign vld = vld_reg & ~ctrl.clr;
    assign age = age_reg;
    assign val = val_reg;
    assign le  = vld && ($signed(val_reg) <= $signed(ctrl.sample));
    assign ev  = ctrl.evict && vld && (age_reg == oldest_age);

    // Once the evicted entry lies at or below this cell, everything moves down by one
    assign at_or_past = below_in | ev;
    assign below_out  = at_or_past;

    // Window after removal, seen at this slot and at the slot below it
    always_comb
    begin
        if (at_or_past)
        begin
            r_vld = right_vld;
            r_age = right_age;
            r_val = right_val;
            r_le  = right_le;
        end
        else
        begin
            r_vld = vld;
            r_age = age_reg;
            r_val = val_reg;
            r_le  = le;
        end
        if (below_in)
        begin
            l_vld = vld;
            l_age = age_reg;
            l_val = val_reg;
            l_le  = le;
        end
        else
        begin
            l_vld = left_vld;
            l_age = left_age;
            l_val = left_val;
            l_le  = left_le;
        end
    end

    always_comb
    begin
        vld_next = r_vld;
        age_next = r_age;
        val_next = r_val;
        if (ctrl.ins)
        begin
            if (r_le)
            begin
                age_next = r_age + 1'b1;
            end
            else if (l_le)
            begin
                vld_next = 1'b1;
                age_next = '0;
                val_next = ctrl.sample;
            end
            else
            begin
                vld_next = l_vld;
                age_next = l_age + 1'b1;
                val_next = l_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        age_reg <= age_next;
        val_reg <= val_next;
    end

endmodule

@@ design/swm_ofifo.sv @@
`timescale 1ns / 1ps
// Small result queue in front of the master stream port.
// Depends on swm_pkg for depth and data width.
module swm_ofifo (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  logic [swm_pkg::DATA_W-1:0]         push_data,
    output logic [swm_pkg::OFIFO_PTR_W-1:0]    count,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [swm_pkg::DATA_W-1:0]         m_tdata
);

    localparam logic [swm_pkg::OFIFO_PTR_W-1:0] LAST_PTR =
        swm_pkg::OFIFO_PTR_W'(swm_pkg::OFIFO_DEPTH - 1);

    logic [swm_pkg::DATA_W-1:0]      mem_reg [swm_pkg::OFIFO_DEPTH];
    logic [swm_pkg::OFIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [swm_pkg::OFIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [swm_pkg::OFIFO_PTR_W-1:0] cnt_reg, cnt_next;
    logic                            pop;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = mem_reg[rd_ptr_reg];
    assign count    = cnt_reg;
    assign pop      = m_tvalid & m_tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/sliding_window_median.sv @@
`timescale 1ns / 1ps
// Sliding window median: a chain of MAX_WINDOW sorted cells updated in parallel.
// A median is flagged in cap_reg, then pushed to the result queue for m_tvalid.
// Throughput: 1 sample per cycle; after the window is shrunk, oldest samples leave
// the chain until the window fits, before the next accept; m_tready stalls the input.
// Reset: window size 1, window empty, no pending result; no clearing pass needed.
// Depends on swm_pkg, swm_cell, swm_ofifo.
module sliding_window_median #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [swm_pkg::DATA_W-1:0]       s_tdata,   // [31:0] sample
    input  logic                             s_tuser,   // [0] start_new
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [swm_pkg::DATA_W-1:0]       m_tdata,   // [31:0] median
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [swm_pkg::WS_W-1:0]         cfg_data
);

    localparam int AGE_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (FILL_W > swm_pkg::WS_W) ? FILL_W : swm_pkg::WS_W;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_WINDOW);

    logic [swm_pkg::WS_W-1:0]   ws_reg;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic                       pend_reg, pend_next;
    logic                       cap_reg, cap_next;

    logic [CMP_W-1:0]           ws_ext;
    logic [FILL_W-1:0]          k;
    logic [FILL_W-1:0]          k_m1;
    logic [FILL_W-1:0]          mid;
    logic [AGE_W-1:0]           mid_idx;
    logic [FILL_W-1:0]          eff;
    logic [FILL_W-1:0]          fill_m1;
    logic [AGE_W-1:0]           oldest_age;
    logic                       k_zero;
    logic                       stall_ev;
    logic                       room;
    logic                       acc;
    logic [swm_pkg::OFIFO_PTR_W-1:0] ocount;
    swm_pkg::cell_ctrl_t        ctrl;

    logic                       c_vld [MAX_WINDOW];
    logic [AGE_W-1:0]           c_age [MAX_WINDOW];
    logic [swm_pkg::DATA_W-1:0] c_val [MAX_WINDOW];
    logic                       c_le  [MAX_WINDOW];
    logic                       c_below [MAX_WINDOW+1];

    // Window size saturates at the chain length
    assign ws_ext  = CMP_W'(ws_reg);
    assign k       = (ws_ext > MAX_C) ? MAX_C[FILL_W-1:0] : ws_ext[FILL_W-1:0];
    assign k_zero  = (k == '0);
    assign k_m1    = k - 1'b1;
    assign mid     = k_m1 >> 1;
    assign mid_idx = mid[AGE_W-1:0];

    // A pending entry is the oldest one, dropped together with the next insert
    assign eff        = fill_reg - FILL_W'(pend_reg);
    assign fill_m1    = fill_reg - 1'b1;
    assign oldest_age = fill_m1[AGE_W-1:0];

    assign stall_ev  = !k_zero && (eff >= k);
    assign room      = ({1'b0, ocount} + {2'b00, cap_reg}) <= 3'd2;
    assign s_tready  = !stall_ev && room;
    assign acc       = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic [FILL_W-1:0] ins_fill;
        ins_fill    = fill_reg + 1'b1;
        ctrl        = '0;
        ctrl.sample = s_tdata;
        fill_next   = fill_reg;
        pend_next   = pend_reg;
        cap_next    = 1'b0;
        if (acc)
        begin
            ctrl.clr = s_tuser;
            if (k_zero)
            begin
                if (s_tuser)
                begin
                    fill_next = '0;
                    pend_next = 1'b0;
                end
            end
            else
            begin
                ctrl.ins   = 1'b1;
                ctrl.evict = pend_reg & ~s_tuser;
                if (s_tuser)
                begin
                    ins_fill = FILL_W'(1);
                end
                else if (pend_reg)
                begin
                    ins_fill = fill_reg;
                end
                fill_next = ins_fill;
                pend_next = (ins_fill == k);
                cap_next  = (ins_fill == k);
            end
        end
        else if (stall_ev)
        begin
            // drop the oldest sample, one per cycle, until the window fits
            ctrl.evict = 1'b1;
            fill_next  = fill_m1;
            pend_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg   <= swm_pkg::WS_W'(1);
            fill_reg <= '0;
            pend_reg <= 1'b0;
            cap_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ws_reg <= cfg_data;
            end
            fill_reg <= fill_next;
            pend_reg <= pend_next;
            cap_reg  <= cap_next;
        end
    end

    assign c_below[0] = 1'b0;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic                       l_vld;
        logic [AGE_W-1:0]           l_age;
        logic [swm_pkg::DATA_W-1:0] l_val;
        logic                       l_le;
        logic                       r_vld;
        logic [AGE_W-1:0]           r_age;
        logic [swm_pkg::DATA_W-1:0] r_val;
        logic                       r_le;

        if (i == 0)
        begin : g_first
            // bottom slot: the new sample lands here if nothing sorts below it
            assign l_vld = 1'b0;
            assign l_age = '0;
            assign l_val = '0;
            assign l_le  = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_vld = c_vld[i-1];
            assign l_age = c_age[i-1];
            assign l_val = c_val[i-1];
            assign l_le  = c_le[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign r_vld = 1'b0;
            assign r_age = '0;
            assign r_val = '0;
            assign r_le  = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_vld = c_vld[i+1];
            assign r_age = c_age[i+1];
            assign r_val = c_val[i+1];
            assign r_le  = c_le[i+1];
        end

        swm_cell #(
            .AGE_W (AGE_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .oldest_age (oldest_age),
            .left_vld   (l_vld),
            .left_age   (l_age),
            .left_val   (l_val),
            .left_le    (l_le),
            .right_vld  (r_vld),
            .right_age  (r_age),
            .right_val  (r_val),
            .right_le   (r_le),
            .below_in   (c_below[i]),
            .below_out  (c_below[i+1]),
            .vld        (c_vld[i]),
            .age        (c_age[i]),
            .val        (c_val[i]),
            .le         (c_le[i])
        );
    end

    // Capture the median from the settled chain the cycle after the filling insert
    swm_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cap_reg),
        .push_data (c_val[mid_idx]),
        .count     (ocount),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
